>>> sv/fadf_pkg.sv
// Package for the frame address and duplicate filter.
// Holds the table geometry, item classes, verdict codes and the queue entry type.
// No dependencies; every other file refers to it by scoped names.
package fadf_pkg;

    // duplicate table geometry
    localparam int TABLE_DEPTH = 8;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // front-to-back queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic REG_OWN_ID   = 1'b0;
    localparam logic REG_BCAST_ID = 1'b1;

    // reset values of the configuration registers
    localparam logic [7:0] OWN_ID_RESET   = 8'd0;
    localparam logic [7:0] BCAST_ID_RESET = 8'd255;

    // command codes on the input tuser
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // class given to an item by the front end
    typedef enum logic [1:0] {
        K_LOOKUP   = 2'd0,
        K_BAD_CRC  = 2'd1,
        K_NOT_ADDR = 2'd2,
        K_CLEAR    = 2'd3
    } t_kind;

    // result verdict codes
    typedef enum logic [2:0] {
        V_DELIVERED = 3'd0,
        V_BAD_CRC   = 3'd1,
        V_NOT_ADDR  = 3'd2,
        V_DUPLICATE = 3'd3,
        V_CLEARED   = 3'd4
    } t_verdict;

    // one classified item as it travels through the queue
    typedef struct packed {
        t_kind      kind;
        logic       self_sent;
        logic [7:0] sender;
        logic [7:0] seq;
        logic [7:0] msg_type;
    } t_item;

endpackage

>>> sv/frame_address_and_duplicate_filter.sv
// Frame address and duplicate filter, top level.
// Holds the configuration registers and ties front end, queue and back end together.
// Depends on fadf_pkg, fadf_front, fadf_queue and fadf_back.
//
// Each input beat is one received frame header (or, with tuser set, a bus-idle
// command that empties the duplicate table) and produces exactly one result beat.
// The front end classifies a beat in the cycle it is taken and drops it into a
// two-entry queue, so input is accepted while the back end is busy or a result
// is waiting. The back end handles one item at a time: a bad-CRC or unaddressed
// frame is answered straight from idle, a table clear or a lookup walks the table
// one table slot per cycle (a match ends the scan early), and a new item starts
// only once the previous result has been taken. No clearing pass follows reset.
module frame_address_and_duplicate_filter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration write channel
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [0:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    // input stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata: sender_id[7:0], dest_id[15:8], seq_number[23:16],
    //        message_type[31:24], crc_residue[47:32]
    input  logic [47:0]   s_axis_tdata,
    // tuser: command[0]
    input  logic [0:0]    s_axis_tuser,
    // result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tdata: out_sender_id[7:0], out_message_type[15:8]
    output logic [15:0]   m_axis_tdata,
    // tuser: verdict[2:0], self_sent[3]
    output logic [3:0]    m_axis_tuser
);

    logic [7:0]         r_own_id;
    logic [7:0]         r_bcast_id;
    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;
    fadf_pkg::t_item    w_front_item;
    fadf_pkg::t_item    w_queue_item;

    // configuration registers, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id   <= fadf_pkg::OWN_ID_RESET;
            r_bcast_id <= fadf_pkg::BCAST_ID_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index[0])
                fadf_pkg::REG_OWN_ID:   r_own_id   <= i_cfg_data;
                fadf_pkg::REG_BCAST_ID: r_bcast_id <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fadf_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_own_id      (r_own_id),
        .i_bcast_id    (r_bcast_id),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_item        (w_front_item)
    );

    fadf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_queue_item),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    fadf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bcast_id    (r_bcast_id),
        .i_q_empty     (w_empty),
        .i_item        (w_queue_item),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> sv/fadf_front.sv
// Front end of the frame filter: takes input beats and classifies them.
// Checks command, CRC residue, destination and own-sender flag.
// Depends on fadf_pkg.
module fadf_front (
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata: sender_id[7:0], dest_id[15:8], seq_number[23:16],
    //        message_type[31:24], crc_residue[47:32]
    input  logic [47:0]         s_axis_tdata,
    // tuser: command[0]
    input  logic [0:0]          s_axis_tuser,
    input  logic [7:0]          i_own_id,
    input  logic [7:0]          i_bcast_id,
    input  logic                i_q_full,
    output logic                o_push,
    output fadf_pkg::t_item     o_item
);

    logic [7:0]  w_sender;
    logic [7:0]  w_dest;
    logic [7:0]  w_seq;
    logic [7:0]  w_type;
    logic [15:0] w_crc;
    logic        w_self;
    logic        w_addressed;

    assign w_sender = s_axis_tdata[7:0];
    assign w_dest   = s_axis_tdata[15:8];
    assign w_seq    = s_axis_tdata[23:16];
    assign w_type   = s_axis_tdata[31:24];
    assign w_crc    = s_axis_tdata[47:32];

    // take a beat whenever the queue has room
    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full;

    assign w_self      = (w_sender == i_own_id);
    assign w_addressed = (w_dest == i_bcast_id) || (w_dest == i_own_id);

    // classify: clear command, bad CRC, not for us, or needs table lookup
    always_comb begin
        o_item.sender    = w_sender;
        o_item.seq       = w_seq;
        o_item.msg_type  = w_type;
        o_item.self_sent = 1'b0;
        if (s_axis_tuser[0] == fadf_pkg::CMD_CLEAR) begin
            o_item.kind = fadf_pkg::K_CLEAR;
        end else if (w_crc != 16'd0) begin
            o_item.kind = fadf_pkg::K_BAD_CRC;
        end else if (!w_addressed) begin
            o_item.kind      = fadf_pkg::K_NOT_ADDR;
            o_item.self_sent = w_self;
        end else begin
            o_item.kind      = fadf_pkg::K_LOOKUP;
            o_item.self_sent = w_self;
        end
    end

endmodule

>>> sv/fadf_queue.sv
// Short first-word-fall-through queue between the front and back ends.
// Holds classified items so that each side can stall on its own.
// Depends on fadf_pkg.
module fadf_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fadf_pkg::t_item     i_item,
    input  logic                i_pop,
    output fadf_pkg::t_item     o_item,
    output logic                o_full,
    output logic                o_empty
);

    fadf_pkg::t_item                  r_mem [fadf_pkg::QUEUE_DEPTH];
    logic [fadf_pkg::QPTR_W-1:0]      r_wptr;
    logic [fadf_pkg::QPTR_W-1:0]      r_rptr;
    logic [fadf_pkg::QCNT_W-1:0]      r_count;
    logic [fadf_pkg::QPTR_W-1:0]      n_wptr;
    logic [fadf_pkg::QPTR_W-1:0]      n_rptr;
    logic [fadf_pkg::QCNT_W-1:0]      n_count;

    localparam logic [fadf_pkg::QPTR_W-1:0] LAST_PTR =
        fadf_pkg::QPTR_W'(fadf_pkg::QUEUE_DEPTH - 1);
    localparam logic [fadf_pkg::QCNT_W-1:0] FULL_CNT =
        fadf_pkg::QCNT_W'(fadf_pkg::QUEUE_DEPTH);

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rptr];

    // pointer and fill count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != FULL_CNT))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue pop while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow push");

endmodule

>>> sv/fadf_back.sv
// Back end of the frame filter: duplicate table, ring head and result register.
// Scans or clears the table one slot per cycle and posts one result per item.
// Depends on fadf_pkg.
module fadf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_bcast_id,
    input  logic                i_q_empty,
    input  fadf_pkg::t_item     i_item,
    output logic                o_pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata: out_sender_id[7:0], out_message_type[15:8]
    output logic [15:0]         m_axis_tdata,
    // tuser: verdict[2:0], self_sent[3]
    output logic [3:0]          m_axis_tuser
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_CLEAR = 3'b100
    } t_state;

    localparam logic [fadf_pkg::IDX_W-1:0] LAST_IDX =
        fadf_pkg::IDX_W'(fadf_pkg::TABLE_DEPTH - 1);

    t_state                         r_state, n_state;
    logic [fadf_pkg::IDX_W-1:0]     r_idx, n_idx;
    logic [fadf_pkg::IDX_W-1:0]     r_head, n_head;
    fadf_pkg::t_item                r_cur, n_cur;
    logic [7:0]                     r_sender [fadf_pkg::TABLE_DEPTH];
    logic [7:0]                     r_seq    [fadf_pkg::TABLE_DEPTH];

    logic                           r_out_valid, n_out_valid;
    fadf_pkg::t_verdict             r_out_verdict, n_out_verdict;
    logic                           r_out_self, n_out_self;
    logic [7:0]                     r_out_sender, n_out_sender;
    logic [7:0]                     r_out_type, n_out_type;

    logic                           w_we;
    logic                           w_seq_we;
    logic [fadf_pkg::IDX_W-1:0]     w_waddr;
    logic [7:0]                     w_wsender;
    logic                           w_hit;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_type, r_out_sender};
    assign m_axis_tuser  = {r_out_self, r_out_verdict};

    // current slot matches an occupied entry with the same sender and sequence
    assign w_hit = (r_sender[r_idx] != i_bcast_id)
                && (r_sender[r_idx] == r_cur.sender)
                && (r_seq[r_idx] == r_cur.seq);

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_head        = r_head;
        n_cur         = r_cur;
        n_out_valid   = r_out_valid;
        n_out_verdict = r_out_verdict;
        n_out_self    = r_out_self;
        n_out_sender  = r_out_sender;
        n_out_type    = r_out_type;
        o_pop         = 1'b0;
        w_we          = 1'b0;
        w_seq_we      = 1'b0;
        w_waddr       = r_idx;
        w_wsender     = i_bcast_id;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // start only with an empty result register
                if (!i_q_empty && !r_out_valid) begin
                    o_pop         = 1'b1;
                    n_cur         = i_item;
                    n_idx         = '0;
                    n_out_self    = 1'b0;
                    n_out_sender  = 8'd0;
                    n_out_type    = 8'd0;
                    case (i_item.kind)
                        fadf_pkg::K_LOOKUP: begin
                            n_state = S_SCAN;
                        end
                        fadf_pkg::K_CLEAR: begin
                            n_state = S_CLEAR;
                        end
                        fadf_pkg::K_BAD_CRC: begin
                            n_out_valid   = 1'b1;
                            n_out_verdict = fadf_pkg::V_BAD_CRC;
                        end
                        fadf_pkg::K_NOT_ADDR: begin
                            n_out_valid   = 1'b1;
                            n_out_verdict = fadf_pkg::V_NOT_ADDR;
                            n_out_self    = i_item.self_sent;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_out_valid   = 1'b1;
                    n_out_verdict = fadf_pkg::V_DUPLICATE;
                    n_out_self    = r_cur.self_sent;
                    n_state       = S_IDLE;
                end else if (r_idx == LAST_IDX) begin
                    // no match: record the pair at the ring head and deliver
                    w_we          = 1'b1;
                    w_seq_we      = 1'b1;
                    w_waddr       = r_head;
                    w_wsender     = r_cur.sender;
                    n_head        = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                    n_out_valid   = 1'b1;
                    n_out_verdict = fadf_pkg::V_DELIVERED;
                    n_out_self    = r_cur.self_sent;
                    n_out_sender  = r_cur.sender;
                    n_out_type    = r_cur.msg_type;
                    n_state       = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_CLEAR: begin
                // mark one slot empty per cycle; sequence and head stay
                w_we = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_out_valid   = 1'b1;
                    n_out_verdict = fadf_pkg::V_CLEARED;
                    n_state       = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur         <= n_cur;
        r_out_verdict <= n_out_verdict;
        r_out_self    <= n_out_self;
        r_out_sender  <= n_out_sender;
        r_out_type    <= n_out_type;
    end

    // duplicate table: senders reset to the broadcast reset value, sequences to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < fadf_pkg::TABLE_DEPTH; k++) begin
                r_sender[k] <= fadf_pkg::BCAST_ID_RESET;
                r_seq[k]    <= 8'd0;
            end
        end else begin
            if (w_we) begin
                r_sender[w_waddr] <= w_wsender;
            end
            if (w_seq_we) begin
                r_seq[w_waddr] <= r_cur.seq;
            end
        end
    end

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE) && !r_out_valid && !i_q_empty)
        else $error("item taken while busy or result pending");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> r_out_valid && $stable(m_axis_tuser)
            && $stable(m_axis_tdata))
        else $error("pending result lost or changed");

    a_head_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> (r_head == $past(r_head)))
        else $error("ring head moved during table clear");

endmodule

>>> dv/tb_top.sv
// Testbench for frame_address_and_duplicate_filter: directed rows, then random frame traffic
// under several ID settings, scored against an in-bench model of the duplicate ring.
// Depends on fadf_pkg and the frame_address_and_duplicate_filter RTL.
module tb_top;

    // one input beat as the bench sees it
    typedef struct packed {
        logic        cmd;
        logic [7:0]  sender;
        logic [7:0]  dest;
        logic [7:0]  seq;
        logic [7:0]  mtype;
        logic [15:0] crc;
    } t_frame;

    // one result beat
    typedef struct packed {
        fadf_pkg::t_verdict verdict;
        logic               self_sent;
        logic [7:0]         sender;
        logic [7:0]         mtype;
    } t_result;

    // directed row: frame plus an optional hand-written result
    typedef struct packed {
        t_frame  frame;
        logic    fixed;
        t_result result;
    } t_stim_row;

    localparam int DIR_ROWS   = 25;
    localparam int NUM_PHASES = 6;
    localparam int PHASE_LEN  = 72;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [0:0]  cfg_index = fadf_pkg::REG_OWN_ID;
    logic [7:0]  cfg_data = 8'h00;
    logic        s_tvalid = 1'b0;
    logic [47:0] s_tdata = '0;
    logic [0:0]  s_tuser = fadf_pkg::CMD_FRAME;
    logic        m_tready = 1'b0;
    logic        o_cfg_ready;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [15:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;

    frame_address_and_duplicate_filter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // model copy of registers and duplicate ring
    logic [7:0]                 own_id;
    logic [7:0]                 bcast_id;
    logic [7:0]                 ring_sender [fadf_pkg::TABLE_DEPTH];
    logic [7:0]                 ring_seq [fadf_pkg::TABLE_DEPTH];
    logic [fadf_pkg::IDX_W-1:0] ring_pos;

    t_result        pending_verdicts [$];
    int             errors = 0;
    bit             src_steady = 1'b0;
    logic [7:0]     sender_pool [6];

    // directed rows, checked under reset IDs (own 0, broadcast 255)
    t_stim_row directed_rows [DIR_ROWS] = '{
        '{'{fadf_pkg::CMD_FRAME, 8'h01, 8'hFF, 8'h00, 8'h10, 16'h0000}, 1'b1,
          '{fadf_pkg::V_DELIVERED, 1'b0, 8'h01, 8'h10}},
        '{'{fadf_pkg::CMD_FRAME, 8'h01, 8'hFF, 8'h00, 8'h20, 16'h0000}, 1'b1,
          '{fadf_pkg::V_DUPLICATE, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_FRAME, 8'h02, 8'hFF, 8'h00, 8'h00, 16'hFFFF}, 1'b1,
          '{fadf_pkg::V_BAD_CRC, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_FRAME, 8'h00, 8'h00, 8'h01, 8'h01, 16'h0001}, 1'b1,
          '{fadf_pkg::V_BAD_CRC, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_FRAME, 8'h00, 8'h12, 8'h01, 8'h01, 16'h0000}, 1'b1,
          '{fadf_pkg::V_NOT_ADDR, 1'b1, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_FRAME, 8'h03, 8'hFE, 8'h05, 8'h05, 16'h0000}, 1'b1,
          '{fadf_pkg::V_NOT_ADDR, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_FRAME, 8'h00, 8'h00, 8'hFF, 8'hFF, 16'h0000}, 1'b1,
          '{fadf_pkg::V_DELIVERED, 1'b1, 8'h00, 8'hFF}},
        '{'{fadf_pkg::CMD_FRAME, 8'hFF, 8'hFF, 8'h07, 8'h33, 16'h0000}, 1'b1,
          '{fadf_pkg::V_DELIVERED, 1'b0, 8'hFF, 8'h33}},
        // broadcast sender lands in an empty slot, so no duplicate
        '{'{fadf_pkg::CMD_FRAME, 8'hFF, 8'hFF, 8'h07, 8'h34, 16'h0000}, 1'b0,
          '{fadf_pkg::V_DELIVERED, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_FRAME, 8'h00, 8'h00, 8'hFF, 8'h00, 16'h0000}, 1'b0,
          '{fadf_pkg::V_DELIVERED, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_CLEAR, 8'hAA, 8'h55, 8'hAA, 8'h55, 16'hA5A5}, 1'b1,
          '{fadf_pkg::V_CLEARED, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_FRAME, 8'h01, 8'hFF, 8'h00, 8'h10, 16'h0000}, 1'b0,
          '{fadf_pkg::V_DELIVERED, 1'b0, 8'h00, 8'h00}},
        // fill the ring so the entry above gets evicted
        '{'{fadf_pkg::CMD_FRAME, 8'h80, 8'h00, 8'h01, 8'h41, 16'h0000}, 1'b0,
          '{fadf_pkg::V_DELIVERED, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_FRAME, 8'h80, 8'h00, 8'h02, 8'h42, 16'h0000}, 1'b0,
          '{fadf_pkg::V_DELIVERED, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_FRAME, 8'h80, 8'h00, 8'h03, 8'h43, 16'h0000}, 1'b0,
          '{fadf_pkg::V_DELIVERED, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_FRAME, 8'h80, 8'h00, 8'h04, 8'h44, 16'h0000}, 1'b0,
          '{fadf_pkg::V_DELIVERED, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_FRAME, 8'h80, 8'h00, 8'h05, 8'h45, 16'h0000}, 1'b0,
          '{fadf_pkg::V_DELIVERED, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_FRAME, 8'h80, 8'h00, 8'h06, 8'h46, 16'h0000}, 1'b0,
          '{fadf_pkg::V_DELIVERED, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_FRAME, 8'h80, 8'h00, 8'h07, 8'h47, 16'h0000}, 1'b0,
          '{fadf_pkg::V_DELIVERED, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_FRAME, 8'h80, 8'h00, 8'h08, 8'h48, 16'h0000}, 1'b0,
          '{fadf_pkg::V_DELIVERED, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_FRAME, 8'h01, 8'hFF, 8'h00, 8'h10, 16'h0000}, 1'b0,
          '{fadf_pkg::V_DELIVERED, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_FRAME, 8'h80, 8'hFF, 8'h01, 8'h41, 16'h0000}, 1'b0,
          '{fadf_pkg::V_DELIVERED, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_FRAME, 8'h80, 8'hFF, 8'h08, 8'h48, 16'h0000}, 1'b0,
          '{fadf_pkg::V_DELIVERED, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_FRAME, 8'h00, 8'hFF, 8'h00, 8'h00, 16'h8000}, 1'b1,
          '{fadf_pkg::V_BAD_CRC, 1'b0, 8'h00, 8'h00}},
        '{'{fadf_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, 1'b1,
          '{fadf_pkg::V_CLEARED, 1'b0, 8'h00, 8'h00}}
    };

    // ID settings per random phase; the broadcast ID changes without a clear in between
    logic [7:0] phase_own   [NUM_PHASES] = '{8'h5A, 8'h00, 8'hFF, 8'h33, 8'h80, 8'hFF};
    logic [7:0] phase_bcast [NUM_PHASES] = '{8'hFF, 8'h00, 8'h00, 8'h33, 8'h7F, 8'hFF};

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // judge one frame against the ring and update it
    function automatic t_result judge_frame(t_frame f);
        t_result r;
        logic    self_hit;
        r = '{fadf_pkg::V_CLEARED, 1'b0, 8'h00, 8'h00};
        if (f.cmd == fadf_pkg::CMD_CLEAR) begin
            for (int i = 0; i < fadf_pkg::TABLE_DEPTH; i++) ring_sender[i] = bcast_id;
            return r;
        end
        if (f.crc != 16'h0000) begin
            r.verdict = fadf_pkg::V_BAD_CRC;
            return r;
        end
        self_hit = (f.sender == own_id);
        r.self_sent = self_hit;
        if (f.dest != bcast_id && f.dest != own_id) begin
            r.verdict = fadf_pkg::V_NOT_ADDR;
            return r;
        end
        // slots holding the current broadcast ID are empty and never match
        for (int i = 0; i < fadf_pkg::TABLE_DEPTH; i++) begin
            if (ring_sender[i] != bcast_id && ring_sender[i] == f.sender &&
                ring_seq[i] == f.seq) begin
                r.verdict = fadf_pkg::V_DUPLICATE;
                return r;
            end
        end
        ring_sender[ring_pos] = f.sender;
        ring_seq[ring_pos]    = f.seq;
        ring_pos = (ring_pos == fadf_pkg::IDX_W'(fadf_pkg::TABLE_DEPTH - 1)) ?
                   '0 : ring_pos + 1'b1;
        r.verdict = fadf_pkg::V_DELIVERED;
        r.sender  = f.sender;
        r.mtype   = f.mtype;
        return r;
    endfunction

    // mostly plausible traffic from a few senders, some noise and clears
    function automatic t_frame random_frame();
        t_frame f;
        int     pick;
        int     dsel;
        pick = $urandom_range(0, 99);
        dsel = $urandom_range(0, 9);
        f.cmd    = fadf_pkg::CMD_FRAME;
        f.sender = sender_pool[$urandom_range(0, 5)];
        f.seq    = 8'($urandom_range(0, 3));
        f.mtype  = 8'($urandom);
        f.dest   = (dsel < 4) ? bcast_id : (dsel < 8) ? own_id : 8'($urandom);
        f.crc    = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000;
        if (pick < 14) begin
            f.sender = 8'($urandom);
            f.dest   = 8'($urandom);
            f.seq    = 8'($urandom);
            f.crc    = $urandom_range(0, 1) ? 16'($urandom) : 16'h0000;
            if (pick < 4) f.cmd = fadf_pkg::CMD_CLEAR;
        end
        return f;
    endfunction

    // offer one beat after a random gap, predict it once taken
    task automatic send_frame(t_frame f, logic use_fixed, t_result fixed);
        int      gap;
        t_result r;
        if ($urandom_range(0, 24) == 0) src_steady = !src_steady;
        gap = src_steady ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {f.crc, f.mtype, f.seq, f.dest, f.sender};
        s_tuser  <= f.cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        r = judge_frame(f);
        pending_verdicts.push_back(use_fixed ? fixed : r);
    endtask

    // wait until every result is back, then let the back end drain
    task automatic settle();
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (fadf_pkg::TABLE_DEPTH + 4) @(posedge i_clk);
    endtask

    // write both ID registers back to back
    task automatic set_ids(logic [7:0] own, logic [7:0] bcast);
        cfg_valid <= 1'b1;
        cfg_index <= fadf_pkg::REG_OWN_ID;
        cfg_data  <= own;
        do @(posedge i_clk); while (!o_cfg_ready);
        own_id = own;
        cfg_index <= fadf_pkg::REG_BCAST_ID;
        cfg_data  <= bcast;
        do @(posedge i_clk); while (!o_cfg_ready);
        bcast_id = bcast;
        cfg_valid <= 1'b0;
    endtask

    task automatic report_field(string what, int want, int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // main stimulus
    initial begin
        t_stim_row row;
        own_id   = fadf_pkg::OWN_ID_RESET;
        bcast_id = fadf_pkg::BCAST_ID_RESET;
        ring_pos = '0;
        for (int i = 0; i < fadf_pkg::TABLE_DEPTH; i++) begin
            ring_sender[i] = fadf_pkg::BCAST_ID_RESET;
            ring_seq[i]    = 8'h00;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < DIR_ROWS; n++) begin
            row = directed_rows[n];
            send_frame(row.frame, row.fixed, row.result);
        end
        s_tvalid <= 1'b0;
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_ids(phase_own[p], phase_bcast[p]);
            sender_pool[0] = own_id;
            sender_pool[1] = bcast_id;
            for (int k = 2; k < 6; k++) sender_pool[k] = 8'($urandom);
            for (int n = 0; n < PHASE_LEN; n++)
                send_frame(random_frame(), 1'b0,
                           '{fadf_pkg::V_DELIVERED, 1'b0, 8'h00, 8'h00});
            s_tvalid <= 1'b0;
            settle();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("frame_address_and_duplicate_filter test passed");
        end else begin
            $display("frame_address_and_duplicate_filter test failed");
        end
        $finish;
    end

    // result side ready pattern, with one long hold-off to back up the input
    initial begin
        int stall;
        bit steady;
        int taken;
        bit held;
        steady = 1'b0;
        taken  = 0;
        held   = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 24) == 0) steady = !steady;
            stall = steady ? 0 : $urandom_range(0, 14);
            if (!held && taken == 80) begin
                stall = 250;
                held  = 1'b1;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_tready));
            taken++;
        end
    end

    // score each result beat against the oldest prediction
    t_result want;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected, tuser %0h tdata %0h",
                         $realtime, m_axis_tuser, m_axis_tdata);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_axis_tuser[2:0] !== want.verdict)
                    report_field("verdict", want.verdict, m_axis_tuser[2:0]);
                if (m_axis_tuser[3] !== want.self_sent)
                    report_field("self_sent", want.self_sent, m_axis_tuser[3]);
                if (m_axis_tdata[7:0] !== want.sender)
                    report_field("sender", want.sender, m_axis_tdata[7:0]);
                if (m_axis_tdata[15:8] !== want.mtype)
                    report_field("message type", want.mtype, m_axis_tdata[15:8]);
            end
        end
    end

    // hang guard
    initial begin
        #2000000;
        $display("frame_address_and_duplicate_filter test failed");
        $finish;
    end

endmodule
